[rtl/i2c_pkg.sv]
// Shared types, sizes and register codes for the im2col address generator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package i2c_pkg;

    localparam int MAX_IMAGE_DIM  = 4096;
    localparam int MAX_FILTER_DIM = 16;
    localparam int MAX_CHANNELS   = 1024;
    localparam int MAX_STRIDE     = 8;
    localparam int MAX_PADDING    = 8;

    // register field widths as written
    localparam int IMG_REG_W    = 13;
    localparam int CHN_REG_W    = 11;
    localparam int FLT_REG_W    = 5;
    localparam int STRIDE_REG_W = 4;
    localparam int PAD_REG_W    = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 3;

    // clamped value widths
    localparam int DIM_W    = $clog2(MAX_IMAGE_DIM + 1);
    localparam int IDX_W    = $clog2(MAX_IMAGE_DIM);
    localparam int CHN_W    = $clog2(MAX_CHANNELS + 1);
    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int FILT_W   = $clog2(MAX_FILTER_DIM + 1);
    localparam int TAP_W    = (MAX_FILTER_DIM > 1) ? $clog2(MAX_FILTER_DIM) : 1;
    localparam int STR_W    = $clog2(MAX_STRIDE + 1);
    localparam int PADV_W   = $clog2(MAX_PADDING + 1);
    localparam int OUT_W    = $clog2(MAX_IMAGE_DIM + 2 * MAX_PADDING + 1);

    // datapath widths
    localparam int RPOS_W    = OUT_W + STR_W + 1;
    localparam int LIN_W     = 2 * IDX_W;
    localparam int PROD_W    = LIN_W + CHN_W;
    localparam int SRC_W     = 34;
    localparam int DEST_W    = 44;
    localparam int DIV_STEPS = OUT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING       = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [CHN_W-1:0]  c;
        logic [FILT_W-1:0] fw;
        logic [FILT_W-1:0] fh;
        logic [STR_W-1:0]  s;
        logic [PADV_W-1:0] p;
        logic [OUT_W-1:0]  ow;
        logic [OUT_W-1:0]  oh;
    } t_geom;

    typedef struct packed {
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [CH_IDX_W-1:0] chan;
        logic [DEST_W-1:0]   dest;
        logic                pad;
        logic                last;
    } t_elem;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [IMG_REG_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (32'(v) > MAX_IMAGE_DIM) return DIM_W'(MAX_IMAGE_DIM);
        return DIM_W'(v);
    endfunction

    function automatic logic [CHN_W-1:0] clamp_chn(input logic [CHN_REG_W-1:0] v);
        if (v == '0) return CHN_W'(1);
        if (32'(v) > MAX_CHANNELS) return CHN_W'(MAX_CHANNELS);
        return CHN_W'(v);
    endfunction

    function automatic logic [FILT_W-1:0] clamp_flt(input logic [FLT_REG_W-1:0] v);
        if (v == '0) return FILT_W'(1);
        if (32'(v) > MAX_FILTER_DIM) return FILT_W'(MAX_FILTER_DIM);
        return FILT_W'(v);
    endfunction

    function automatic logic [STR_W-1:0] clamp_str(input logic [STRIDE_REG_W-1:0] v);
        if (v == '0) return STR_W'(1);
        if (32'(v) > MAX_STRIDE) return STR_W'(MAX_STRIDE);
        return STR_W'(v);
    endfunction

    function automatic logic [PADV_W-1:0] clamp_pad(input logic [PAD_REG_W-1:0] v);
        if (32'(v) > MAX_PADDING) return PADV_W'(MAX_PADDING);
        return PADV_W'(v);
    endfunction

endpackage

[rtl/i2c_config.sv]
// Configuration registers, clamping and the serial stride divider that
// derives the output width and height. Depends on i2c_pkg.
`timescale 1ns / 1ps

module i2c_config (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [i2c_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [i2c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output i2c_pkg::t_geom                 o_geom,
    output logic                           o_busy
);
    import i2c_pkg::*;

    logic [IMG_REG_W-1:0]    r_image_width;
    logic [IMG_REG_W-1:0]    r_image_height;
    logic [CHN_REG_W-1:0]    r_channels;
    logic [FLT_REG_W-1:0]    r_filter_width;
    logic [FLT_REG_W-1:0]    r_filter_height;
    logic [STRIDE_REG_W-1:0] r_stride;
    logic [PAD_REG_W-1:0]    r_padding;

    logic                 r_pend;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [OUT_W-1:0]     r_nq_w, r_nq_h;
    logic [STR_W-1:0]     r_rem_w, r_rem_h;
    logic                 r_small_w, r_small_h;

    logic [OUT_W-1:0] padded_w, padded_h;
    logic [STR_W-1:0] t_w, t_h;
    logic             ge_w, ge_h;
    logic [OUT_W-1:0] n_nq_w, n_nq_h;
    logic [STR_W-1:0] n_rem_w, n_rem_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= IMG_REG_W'(1);
            r_image_height  <= IMG_REG_W'(1);
            r_channels      <= CHN_REG_W'(1);
            r_filter_width  <= FLT_REG_W'(1);
            r_filter_height <= FLT_REG_W'(1);
            r_stride        <= STRIDE_REG_W'(1);
            r_padding       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[IMG_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[IMG_REG_W-1:0];
                CFG_CHANNELS:      r_channels      <= i_cfg_data[CHN_REG_W-1:0];
                CFG_FILTER_WIDTH:  r_filter_width  <= i_cfg_data[FLT_REG_W-1:0];
                CFG_FILTER_HEIGHT: r_filter_height <= i_cfg_data[FLT_REG_W-1:0];
                CFG_STRIDE:        r_stride        <= i_cfg_data[STRIDE_REG_W-1:0];
                CFG_PADDING:       r_padding       <= i_cfg_data[PAD_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_geom.w  = clamp_dim(r_image_width);
        o_geom.h  = clamp_dim(r_image_height);
        o_geom.c  = clamp_chn(r_channels);
        o_geom.fw = clamp_flt(r_filter_width);
        o_geom.fh = clamp_flt(r_filter_height);
        o_geom.s  = clamp_str(r_stride);
        o_geom.p  = clamp_pad(r_padding);
        o_geom.ow = r_small_w ? OUT_W'(1) : r_nq_w + OUT_W'(1);
        o_geom.oh = r_small_h ? OUT_W'(1) : r_nq_h + OUT_W'(1);
    end

    assign padded_w = OUT_W'(o_geom.w) + OUT_W'({o_geom.p, 1'b0});
    assign padded_h = OUT_W'(o_geom.h) + OUT_W'({o_geom.p, 1'b0});

    // one restoring quotient bit per cycle for each dimension
    always_comb begin
        t_w     = {r_rem_w[STR_W-2:0], r_nq_w[OUT_W-1]};
        t_h     = {r_rem_h[STR_W-2:0], r_nq_h[OUT_W-1]};
        ge_w    = t_w >= o_geom.s;
        ge_h    = t_h >= o_geom.s;
        n_rem_w = ge_w ? t_w - o_geom.s : t_w;
        n_rem_h = ge_h ? t_h - o_geom.s : t_h;
        n_nq_w  = {r_nq_w[OUT_W-2:0], ge_w};
        n_nq_h  = {r_nq_h[OUT_W-2:0], ge_h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_cnt     <= '0;
            r_nq_w    <= '0;
            r_nq_h    <= '0;
            r_rem_w   <= '0;
            r_rem_h   <= '0;
            r_small_w <= 1'b0;
            r_small_h <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pend <= 1'b1;
            end else if (r_pend) begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                r_small_w <= padded_w < OUT_W'(o_geom.fw);
                r_small_h <= padded_h < OUT_W'(o_geom.fh);
                r_nq_w    <= padded_w - OUT_W'(o_geom.fw);
                r_nq_h    <= padded_h - OUT_W'(o_geom.fh);
                r_rem_w   <= '0;
                r_rem_h   <= '0;
                r_cnt     <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_nq_w  <= n_nq_w;
                r_nq_h  <= n_nq_h;
                r_rem_w <= n_rem_w;
                r_rem_h <= n_rem_h;
                r_cnt   <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    assign o_busy = r_pend || (r_cnt != '0);

endmodule

[rtl/i2c_walk.sv]
// Front end: accepts requests, steps the unfold counters and classifies each
// element (padding, last, source row and column). Depends on i2c_pkg.
`timescale 1ns / 1ps

module i2c_walk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_restart,
    output logic           o_stall,
    input  i2c_pkg::t_geom i_geom,
    input  logic           i_busy,
    input  logic           i_q_full,
    output logic           o_push,
    output i2c_pkg::t_elem o_elem
);
    import i2c_pkg::*;

    logic [OUT_W-1:0]    r_out_row, r_out_col;
    logic [TAP_W-1:0]    r_tap_row, r_tap_col;
    logic [CH_IDX_W-1:0] r_chan;
    logic [DEST_W-1:0]   r_dest;

    logic [OUT_W-1:0]    e_out_row, e_out_col;
    logic [TAP_W-1:0]    e_tap_row, e_tap_col;
    logic [CH_IDX_W-1:0] e_chan;
    logic [DEST_W-1:0]   e_dest;

    logic [OUT_W-1:0]    n_out_row, n_out_col;
    logic [TAP_W-1:0]    n_tap_row, n_tap_col;
    logic [CH_IDX_W-1:0] n_chan;
    logic [DEST_W-1:0]   n_dest;

    logic [RPOS_W-1:0] rpos, cpos, rrow, rcol;
    logic              pad;
    logic              wrap_ch, wrap_tc, wrap_tr, wrap_oc, wrap_or, last;
    logic              accept;

    assign o_stall = i_busy || i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = accept;

    always_comb begin
        e_out_row = i_restart ? '0 : r_out_row;
        e_out_col = i_restart ? '0 : r_out_col;
        e_tap_row = i_restart ? '0 : r_tap_row;
        e_tap_col = i_restart ? '0 : r_tap_col;
        e_chan    = i_restart ? '0 : r_chan;
        e_dest    = i_restart ? '0 : r_dest;

        rpos = RPOS_W'(e_out_row) * RPOS_W'(i_geom.s) + RPOS_W'(e_tap_row);
        cpos = RPOS_W'(e_out_col) * RPOS_W'(i_geom.s) + RPOS_W'(e_tap_col);
        rrow = rpos - RPOS_W'(i_geom.p);
        rcol = cpos - RPOS_W'(i_geom.p);
        pad  = (rpos < RPOS_W'(i_geom.p)) || (cpos < RPOS_W'(i_geom.p)) ||
               (rrow >= RPOS_W'(i_geom.h)) || (rcol >= RPOS_W'(i_geom.w));

        wrap_ch = (CHN_W'(e_chan) + CHN_W'(1)) >= i_geom.c;
        wrap_tc = (FILT_W'(e_tap_col) + FILT_W'(1)) >= i_geom.fw;
        wrap_tr = (FILT_W'(e_tap_row) + FILT_W'(1)) >= i_geom.fh;
        wrap_oc = ((OUT_W+1)'(e_out_col) + (OUT_W+1)'(1)) >= (OUT_W+1)'(i_geom.ow);
        wrap_or = ((OUT_W+1)'(e_out_row) + (OUT_W+1)'(1)) >= (OUT_W+1)'(i_geom.oh);
        last    = wrap_ch && wrap_tc && wrap_tr && wrap_oc && wrap_or;

        n_chan    = e_chan;
        n_tap_col = e_tap_col;
        n_tap_row = e_tap_row;
        n_out_col = e_out_col;
        n_out_row = e_out_row;
        n_dest    = e_dest + DEST_W'(1);
        if (last) begin
            n_chan    = '0;
            n_tap_col = '0;
            n_tap_row = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_dest    = '0;
        end else begin
            n_chan = wrap_ch ? '0 : e_chan + CH_IDX_W'(1);
            if (wrap_ch) begin
                n_tap_col = wrap_tc ? '0 : e_tap_col + TAP_W'(1);
                if (wrap_tc) begin
                    n_tap_row = wrap_tr ? '0 : e_tap_row + TAP_W'(1);
                    if (wrap_tr) begin
                        n_out_col = wrap_oc ? '0 : e_out_col + OUT_W'(1);
                        if (wrap_oc) begin
                            n_out_row = wrap_or ? '0 : e_out_row + OUT_W'(1);
                        end
                    end
                end
            end
        end

        o_elem.row  = rrow[IDX_W-1:0];
        o_elem.col  = rcol[IDX_W-1:0];
        o_elem.chan = e_chan;
        o_elem.dest = e_dest;
        o_elem.pad  = pad;
        o_elem.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_row <= '0;
            r_out_col <= '0;
            r_tap_row <= '0;
            r_tap_col <= '0;
            r_chan    <= '0;
            r_dest    <= '0;
        end else if (accept) begin
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_tap_row <= n_tap_row;
            r_tap_col <= n_tap_col;
            r_chan    <= n_chan;
            r_dest    <= n_dest;
        end
    end

endmodule

[rtl/i2c_queue.sv]
// Short element queue between the counter front end and the address back end.
// Depends on i2c_pkg.
`timescale 1ns / 1ps

module i2c_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2c_pkg::t_elem i_elem,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output i2c_pkg::t_elem o_elem
);
    import i2c_pkg::*;

    t_elem             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_elem  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

[rtl/i2c_addr.sv]
// Back end: two-stage multiply pipeline forming the source index, with the
// output register as its second stage. Depends on i2c_pkg.
`timescale 1ns / 1ps

module i2c_addr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  i2c_pkg::t_geom              i_geom,
    input  logic                        i_q_valid,
    input  i2c_pkg::t_elem              i_elem,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [i2c_pkg::SRC_W-1:0]   o_source_index,
    output logic [i2c_pkg::DEST_W-1:0]  o_dest_index,
    output logic                        o_is_padding,
    output logic                        o_last,
    output logic                        o_s1_valid
);
    import i2c_pkg::*;

    logic                r_s1_valid;
    logic [LIN_W-1:0]    r_s1_lin;
    logic [CH_IDX_W-1:0] r_s1_chan;
    logic [DEST_W-1:0]   r_s1_dest;
    logic                r_s1_pad;
    logic                r_s1_last;

    logic              r_out_valid;
    logic [SRC_W-1:0]  r_src;
    logic [DEST_W-1:0] r_dest;
    logic              r_pad;
    logic              r_last;

    logic adv;

    assign adv   = !(r_out_valid && i_stall);
    assign o_pop = adv && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_q_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_lin  <= LIN_W'(i_elem.row) * LIN_W'(i_geom.w) + LIN_W'(i_elem.col);
            r_s1_chan <= i_elem.chan;
            r_s1_dest <= i_elem.dest;
            r_s1_pad  <= i_elem.pad;
            r_s1_last <= i_elem.last;
            r_src     <= r_s1_pad ? '0 :
                         SRC_W'(PROD_W'(r_s1_lin) * PROD_W'(i_geom.c) + PROD_W'(r_s1_chan));
            r_dest    <= r_s1_dest;
            r_pad     <= r_s1_pad;
            r_last    <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_source_index = r_src;
    assign o_dest_index   = r_dest;
    assign o_is_padding   = r_pad;
    assign o_last         = r_last;
    assign o_s1_valid     = r_s1_valid;

endmodule

[rtl/im2col_address_generator.sv]
// im2col address generator top level: config, counter front end, queue, back end.
// Requests pass the queue, stage 1 and output register; one per cycle unless stalled.
// After any config write the input stalls while the stride divider runs.
// Reset (synchronous, active low): registers to defaults, counters and queue empty.
// Depends on i2c_pkg, i2c_config, i2c_walk, i2c_queue, i2c_addr.
`timescale 1ns / 1ps

module im2col_address_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [i2c_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [i2c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_restart,
    output logic                           o_stall,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [i2c_pkg::SRC_W-1:0]      o_source_index,
    output logic [i2c_pkg::DEST_W-1:0]     o_dest_index,
    output logic                           o_is_padding,
    output logic                           o_last
);
    import i2c_pkg::*;

    t_geom geom;
    logic  cfg_busy;
    logic  q_push, q_pop, q_valid, q_full;
    t_elem walk_elem, q_elem;
    logic  s1_valid;

    i2c_config u_config (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_busy     (cfg_busy)
    );

    i2c_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_restart (i_restart),
        .o_stall   (o_stall),
        .i_geom    (geom),
        .i_busy    (cfg_busy),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_elem    (walk_elem)
    );

    i2c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_elem  (walk_elem),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_elem  (q_elem)
    );

    i2c_addr u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_q_valid      (q_valid),
        .i_elem         (q_elem),
        .o_pop          (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_source_index (o_source_index),
        .o_dest_index   (o_dest_index),
        .o_is_padding   (o_is_padding),
        .o_last         (o_last),
        .o_s1_valid     (s1_valid)
    );

`ifndef NO_ASSERTIONS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_busy |-> o_stall)
        else $error("request accepted while geometry divider busy");

    a_pad_zero_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_padding) |-> (o_source_index == '0))
        else $error("padding element with nonzero source index");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s1_valid))
        else $error("output valid without a stage-1 element");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");
`endif

endmodule

[tb/tb_im2col_address_generator.sv]
// Self-checking testbench for im2col_address_generator: directed table, then random phases.
// Predicts every column-matrix element and checks the result stream field by field.
// Depends on i2c_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_im2col_address_generator;

    import i2c_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_REGS     = 7;

    typedef struct packed {
        logic [SRC_W-1:0]  src;
        logic [DEST_W-1:0] dest;
        logic              pad;
        logic              last;
    } col_elem_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        logic                  typed;
        logic [SRC_W-1:0]      src;
        logic [DEST_W-1:0]     dest;
        logic                  pad;
        logic                  last;
    } dir_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_CODES [NUM_REGS] = '{
        CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_CHANNELS, CFG_FILTER_WIDTH,
        CFG_FILTER_HEIGHT, CFG_STRIDE, CFG_PADDING
    };

    localparam int NUM_ROWS = 39;
    localparam dir_row_t DIRECTED [NUM_ROWS] = '{
        // reset geometry: one element per frame
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b1, 34'd0, 44'd0, 1'b0, 1'b1},
        '{ROW_ITEM, '0, 13'd0, 1'b1, 1'b1, 34'd0, 44'd0, 1'b0, 1'b1},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b1, 34'd0, 44'd0, 1'b0, 1'b1},
        // small padded image
        '{ROW_CFG, CFG_IMAGE_WIDTH,   13'd3, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_IMAGE_HEIGHT,  13'd2, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_CHANNELS,      13'd2, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_FILTER_WIDTH,  13'd2, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_FILTER_HEIGHT, 13'd2, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_STRIDE,        13'd1, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_PADDING,       13'd1, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b1, 1'b1, 34'd0, 44'd0, 1'b1, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        // restart in the middle of a frame
        '{ROW_ITEM, '0, 13'd0, 1'b1, 1'b1, 34'd0, 44'd0, 1'b1, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        // out-of-range registers, used clamped
        '{ROW_CFG, CFG_IMAGE_WIDTH,   13'd0,    1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_IMAGE_HEIGHT,  13'h1FFF, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_CHANNELS,      13'h07FF, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_FILTER_WIDTH,  13'd31,   1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_FILTER_HEIGHT, 13'd0,    1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_STRIDE,        13'd15,   1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_PADDING,       13'd15,   1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b1, 1'b1, 34'd0, 44'd0, 1'b1, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        // window wider than the padded image
        '{ROW_CFG, CFG_IMAGE_WIDTH,   13'd1, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_PADDING,       13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_CHANNELS,      13'd1, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b1, 1'b1, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, 13'd0, 1'b0, 1'b0, 34'd0, 44'd0, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  i_restart;
    logic                  o_stall;
    logic                  o_valid;
    logic                  i_stall;
    logic [SRC_W-1:0]      o_source_index;
    logic [DEST_W-1:0]     o_dest_index;
    logic                  o_is_padding;
    logic                  o_last;

    im2col_address_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_restart      (i_restart),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_source_index (o_source_index),
        .o_dest_index   (o_dest_index),
        .o_is_padding   (o_is_padding),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // model copy of registers (stored bits) and walk counters
    logic [CFG_DATA_W-1:0] cfg_w = 13'd1, cfg_h = 13'd1, cfg_c = 13'd1;
    logic [CFG_DATA_W-1:0] cfg_fw = 13'd1, cfg_fh = 13'd1, cfg_s = 13'd1, cfg_p = 13'd0;
    int unsigned orow = 0, ocol = 0, trow = 0, tcol = 0, chan = 0;
    logic [DEST_W-1:0] dest_cnt = '0;

    col_elem_t pending_elems [$];
    int  errors = 0;
    bit  quiet  = 1'b0;

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned win_positions(int unsigned size, int unsigned pad,
                                                  int unsigned win, int unsigned step);
        int unsigned padded;
        padded = size + 2 * pad;
        if (padded < win) return 1;
        return (padded - win) / step + 1;
    endfunction

    function automatic bit bump(inout int unsigned cnt, input int unsigned lim);
        if (cnt + 1 >= lim) begin
            cnt = 0;
            return 1'b1;
        end
        cnt = cnt + 1;
        return 1'b0;
    endfunction

    function automatic void clear_walk();
        orow = 0; ocol = 0; trow = 0; tcol = 0; chan = 0;
        dest_cnt = '0;
    endfunction

    function automatic void store_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:   cfg_w  = CFG_DATA_W'(data[IMG_REG_W-1:0]);
            CFG_IMAGE_HEIGHT:  cfg_h  = CFG_DATA_W'(data[IMG_REG_W-1:0]);
            CFG_CHANNELS:      cfg_c  = CFG_DATA_W'(data[CHN_REG_W-1:0]);
            CFG_FILTER_WIDTH:  cfg_fw = CFG_DATA_W'(data[FLT_REG_W-1:0]);
            CFG_FILTER_HEIGHT: cfg_fh = CFG_DATA_W'(data[FLT_REG_W-1:0]);
            CFG_STRIDE:        cfg_s  = CFG_DATA_W'(data[STRIDE_REG_W-1:0]);
            CFG_PADDING:       cfg_p  = CFG_DATA_W'(data[PAD_REG_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic col_elem_t next_column_elem(logic restart);
        int unsigned w, h, c, fw, fh, s, p, ow, oh;
        longint      row, col;
        col_elem_t   e;
        w  = clamp_range(32'(cfg_w), 1, MAX_IMAGE_DIM);
        h  = clamp_range(32'(cfg_h), 1, MAX_IMAGE_DIM);
        c  = clamp_range(32'(cfg_c), 1, MAX_CHANNELS);
        fw = clamp_range(32'(cfg_fw), 1, MAX_FILTER_DIM);
        fh = clamp_range(32'(cfg_fh), 1, MAX_FILTER_DIM);
        s  = clamp_range(32'(cfg_s), 1, MAX_STRIDE);
        p  = clamp_range(32'(cfg_p), 0, MAX_PADDING);
        ow = win_positions(w, p, fw, s);
        oh = win_positions(h, p, fh, s);
        if (restart) clear_walk();
        row = longint'(trow) + longint'(orow) * longint'(s) - longint'(p);
        col = longint'(tcol) + longint'(ocol) * longint'(s) - longint'(p);
        e.pad = (row < 0) || (col < 0) || (row >= longint'(h)) || (col >= longint'(w));
        e.src = '0;
        if (!e.pad) e.src = SRC_W'((row * longint'(w) + col) * longint'(c) + longint'(chan));
        e.dest = dest_cnt;
        e.last = (chan + 1 >= c) && (tcol + 1 >= fw) && (trow + 1 >= fh) &&
                 (ocol + 1 >= ow) && (orow + 1 >= oh);
        if (e.last) begin
            clear_walk();
        end else begin
            dest_cnt = dest_cnt + 1'b1;
            if (bump(chan, c))
                if (bump(tcol, fw))
                    if (bump(trow, fh))
                        if (bump(ocol, ow))
                            void'(bump(orow, oh));
        end
        return e;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_value(logic [CFG_IDX_W-1:0] idx, int mode);
        int unsigned lo, hi, hi_small;
        case (idx)
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: begin lo = 1; hi = MAX_IMAGE_DIM;  hi_small = 4; end
            CFG_CHANNELS:                      begin lo = 1; hi = MAX_CHANNELS;   hi_small = 2; end
            CFG_FILTER_WIDTH, CFG_FILTER_HEIGHT: begin
                lo = 1; hi = MAX_FILTER_DIM; hi_small = 3;
            end
            CFG_STRIDE:                        begin lo = 1; hi = MAX_STRIDE;     hi_small = 2; end
            default:                           begin lo = 0; hi = MAX_PADDING;    hi_small = 1; end
        endcase
        if (mode < 7) return CFG_DATA_W'($urandom_range(lo, hi_small));
        if (mode == 9) return CFG_DATA_W'($urandom_range(0, 8191));
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CFG_DATA_W'(lo);
            2: return CFG_DATA_W'(hi);
            3: return CFG_DATA_W'(hi + 1);
            default: return '1;
        endcase
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        col_elem_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_elems.size() == 0) begin
                errors++;
                $display("%0t: result expected none got dest_index %0h",
                         $time, o_dest_index);
            end else begin
                want = pending_elems.pop_front();
                compare_field("source_index", 64'(want.src),  64'(o_source_index));
                compare_field("dest_index",   64'(want.dest), 64'(o_dest_index));
                compare_field("is_padding",   64'(want.pad),  64'(o_is_padding));
                compare_field("last",         64'(want.last), 64'(o_last));
            end
        end
    end

    task automatic send_request(input logic restart, input logic typed, input col_elem_t typed_elem);
        int        gap;
        col_elem_t predicted;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = next_column_elem(restart);
        pending_elems.push_back(typed ? typed_elem : predicted);
    endtask

    task automatic drain_results();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        store_cfg(idx, data);
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    initial begin : stall_gen
        int n;
        i_stall = 1'b0;
        forever begin
            n = idle_len();
            if (!quiet && n > 0) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            n = $urandom_range(1, 12);
            @(negedge i_clk) i_stall <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int        random_items;
        int        n;
        int        mode;
        bit        partial;
        col_elem_t typed_elem;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_restart  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_register(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                typed_elem = '{DIRECTED[r].src, DIRECTED[r].dest, DIRECTED[r].pad,
                               DIRECTED[r].last};
                send_request(DIRECTED[r].restart, DIRECTED[r].typed, typed_elem);
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            quiet   = ($urandom_range(0, 3) == 0);
            mode    = $urandom_range(0, 9);
            partial = ($urandom_range(0, 4) == 0);
            for (int r = 0; r < NUM_REGS; r++)
                if (!partial || $urandom_range(0, 1) == 1)
                    write_register(REG_CODES[r], pick_value(REG_CODES[r], mode));
            n = $urandom_range(20, 100);
            for (int k = 0; k < n; k++)
                send_request((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0),
                             1'b0, '0);
            random_items += n;
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_elems.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
